// File: rtl/core/bdrb_pkg.sv
// shared types, constants and helpers for the byte deque ring buffer
package bdrb_pkg;

	localparam int DEPTH_LOG2 = 10;
	localparam int MAX_AMOUNT = 64;
	localparam int DEPTH      = 1 << DEPTH_LOG2;
	localparam int AW         = DEPTH_LOG2;
	localparam int PTR_W      = DEPTH_LOG2 + 1;
	localparam int AMT_W      = 7;
	localparam int IDX_W      = 11;
	localparam int CFG_W      = 4;
	localparam logic [CFG_W-1:0] CAP_LOG2_RST = CFG_W'(10);

	typedef enum logic [3:0] {
		K_PUSH_BACK  = 4'd0,
		K_PUSH_FRONT = 4'd1,
		K_OVERWRITE  = 4'd2,
		K_POP_FRONT  = 4'd3,
		K_POP_BACK   = 4'd4,
		K_DROP_FRONT = 4'd5,
		K_DROP_BACK  = 4'd6,
		K_FIND_FRONT = 4'd7,
		K_FIND_BACK  = 4'd8,
		K_CLEAR      = 4'd9
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_EMPTY     = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP,
		ST_FIND
	} state_t;

	typedef struct packed {
		logic [3:0]       kind;
		logic [7:0]       data_in;
		logic [AMT_W-1:0] amount;
	} req_t;

	typedef struct packed {
		logic [7:0]       data_out;
		logic [1:0]       status;
		logic [IDX_W-1:0] index;
		logic [IDX_W-1:0] occupancy;
		logic             last;
	} rsp_t;

	// store address of a free-running pointer under the capacity mask
	function automatic logic [AW-1:0] slot(input logic [PTR_W-1:0] p,
		input logic [AW-1:0] m);
		return p[AW-1:0] & m;
	endfunction

endpackage

// File: rtl/core/byte_deque_ring_buffer_unit.sv
// byte deque ring buffer: pointers, control sequencer and byte store
// push, overwrite, drop, clear and empty cases: the result word is registered at accept
// pop: first byte via the read and result registers, then one byte a cycle while rsp_ready holds
// find: one store read a cycle, stopping at a hit or after the last held byte
// next word taken when idle, result register free, no cfg_valid; single read port sets the pace
// reset: both pointers 0, capacity 2^10; the byte store is not cleared
module byte_deque_ring_buffer_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  bdrb_pkg::req_t              req,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output bdrb_pkg::rsp_t              rsp,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [bdrb_pkg::CFG_W-1:0]  cfg_data
);

	bdrb_pkg::state_t state_q, state_d;

	logic [bdrb_pkg::PTR_W-1:0] head_q, head_d, tail_q, tail_d;
	logic [bdrb_pkg::CFG_W-1:0] cap_log2_q, cap_eff;
	logic [bdrb_pkg::PTR_W-1:0] cap_bytes, occ, nxt_cnt, walk_ptr;
	logic [bdrb_pkg::AW-1:0]    mask;
	logic [bdrb_pkg::AMT_W-1:0] amt_c, take_n, left_q, left_d;
	logic [bdrb_pkg::PTR_W-1:0] cnt_q, cnt_d;
	logic [7:0]                 key_q, key_d;
	logic                       back_q, back_d;

	logic req_acc, cfg_acc, out_free, full;
	logic is_pop, is_find, pop_start, find_start, hit, find_end, pop_end;

	logic                    ram_we, ram_re;
	logic [bdrb_pkg::AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]              ram_rdata;

	logic           ld;
	bdrb_pkg::rsp_t rsp_d, rsp_q;
	logic           rsp_valid_q;

	// capacity clamp and mask
	always_comb begin
		if (cap_log2_q < bdrb_pkg::CFG_W'(1)) begin
			cap_eff = bdrb_pkg::CFG_W'(1);
		end else if (int'(cap_log2_q) > bdrb_pkg::DEPTH_LOG2) begin
			cap_eff = bdrb_pkg::CFG_W'(bdrb_pkg::DEPTH_LOG2);
		end else begin
			cap_eff = cap_log2_q;
		end
	end

	assign cap_bytes = bdrb_pkg::PTR_W'(1) << cap_eff;
	assign mask      = cap_bytes[bdrb_pkg::AW-1:0] - bdrb_pkg::AW'(1);
	assign occ       = head_q - tail_q;
	assign full      = occ >= cap_bytes;

	assign amt_c  = (req.amount > bdrb_pkg::AMT_W'(bdrb_pkg::MAX_AMOUNT)) ?
		bdrb_pkg::AMT_W'(bdrb_pkg::MAX_AMOUNT) : req.amount;
	assign take_n = (bdrb_pkg::PTR_W'(amt_c) < occ) ? amt_c : occ[bdrb_pkg::AMT_W-1:0];

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign cfg_ready = (state_q == bdrb_pkg::ST_IDLE);
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign req_ready = (state_q == bdrb_pkg::ST_IDLE) && out_free && !cfg_valid;
	assign req_acc   = req_valid && req_ready;

	assign is_pop  = req.kind inside {bdrb_pkg::K_POP_FRONT, bdrb_pkg::K_POP_BACK};
	assign is_find = req.kind inside {bdrb_pkg::K_FIND_FRONT, bdrb_pkg::K_FIND_BACK};

	assign pop_start  = req_acc && is_pop && (amt_c != '0) && (occ != '0);
	assign find_start = req_acc && is_find && (occ != '0);
	assign pop_end    = out_free && (left_q == bdrb_pkg::AMT_W'(1));

	// byte under compare belongs to position cnt_q
	assign hit      = (ram_rdata == key_q);
	assign nxt_cnt  = cnt_q + bdrb_pkg::PTR_W'(1);
	assign find_end = hit || (nxt_cnt == occ);
	assign walk_ptr = back_q ? (head_q - bdrb_pkg::PTR_W'(1) - nxt_cnt) : (tail_q + nxt_cnt);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bdrb_pkg::ST_IDLE: begin
				if (pop_start) begin
					state_d = bdrb_pkg::ST_POP;
				end else if (find_start) begin
					state_d = bdrb_pkg::ST_FIND;
				end
			end
			bdrb_pkg::ST_POP: begin
				if (pop_end) begin
					state_d = bdrb_pkg::ST_IDLE;
				end
			end
			bdrb_pkg::ST_FIND: begin
				if (find_end) begin
					state_d = bdrb_pkg::ST_IDLE;
				end
			end
			default: state_d = bdrb_pkg::ST_IDLE;
		endcase
	end

	// datapath control
	always_comb begin
		head_d    = head_q;
		tail_d    = tail_q;
		ram_we    = 1'b0;
		ram_waddr = bdrb_pkg::slot(head_q, mask);
		ram_re    = 1'b0;
		ram_raddr = bdrb_pkg::slot(tail_q, mask);
		left_d    = left_q;
		cnt_d     = cnt_q;
		key_d     = key_q;
		back_d    = back_q;
		ld        = 1'b0;
		rsp_d     = '0;
		rsp_d.last = 1'b1;
		rsp_d.status = bdrb_pkg::STAT_OK;

		case (state_q)
			bdrb_pkg::ST_IDLE: begin
				if (req_acc) begin
					ld     = 1'b1;
					key_d  = req.data_in;
					back_d = req.kind inside {bdrb_pkg::K_POP_BACK, bdrb_pkg::K_FIND_BACK};
					case (req.kind)
						bdrb_pkg::K_PUSH_BACK: begin
							if (full) begin
								rsp_d.status = bdrb_pkg::STAT_FULL;
							end else begin
								ram_we = 1'b1;
								head_d = head_q + bdrb_pkg::PTR_W'(1);
							end
						end
						bdrb_pkg::K_PUSH_FRONT: begin
							if (full) begin
								rsp_d.status = bdrb_pkg::STAT_FULL;
							end else begin
								tail_d    = tail_q - bdrb_pkg::PTR_W'(1);
								ram_we    = 1'b1;
								ram_waddr = bdrb_pkg::slot(tail_d, mask);
							end
						end
						bdrb_pkg::K_OVERWRITE: begin
							// full: oldest byte goes first
							if (full) begin
								tail_d       = tail_q + bdrb_pkg::PTR_W'(1);
								rsp_d.status = bdrb_pkg::STAT_FULL;
							end
							ram_we = 1'b1;
							head_d = head_q + bdrb_pkg::PTR_W'(1);
						end
						bdrb_pkg::K_POP_FRONT, bdrb_pkg::K_POP_BACK: begin
							if (amt_c == '0) begin
								rsp_d.status = bdrb_pkg::STAT_OK;
							end else if (occ == '0) begin
								rsp_d.status = bdrb_pkg::STAT_EMPTY;
							end else begin
								ld     = 1'b0;
								ram_re = 1'b1;
								left_d = take_n;
								if (req.kind == bdrb_pkg::K_POP_BACK) begin
									head_d    = head_q - bdrb_pkg::PTR_W'(1);
									ram_raddr = bdrb_pkg::slot(head_d, mask);
								end else begin
									tail_d = tail_q + bdrb_pkg::PTR_W'(1);
								end
							end
						end
						bdrb_pkg::K_DROP_FRONT, bdrb_pkg::K_DROP_BACK: begin
							if (req.kind == bdrb_pkg::K_DROP_FRONT) begin
								tail_d = tail_q + bdrb_pkg::PTR_W'(take_n);
							end else begin
								head_d = head_q - bdrb_pkg::PTR_W'(take_n);
							end
							rsp_d.index = bdrb_pkg::IDX_W'(take_n);
							if ((amt_c != '0) && (occ == '0)) begin
								rsp_d.status = bdrb_pkg::STAT_EMPTY;
							end
						end
						bdrb_pkg::K_FIND_FRONT, bdrb_pkg::K_FIND_BACK: begin
							if (occ == '0) begin
								rsp_d.status = bdrb_pkg::STAT_NOT_FOUND;
							end else begin
								ld     = 1'b0;
								ram_re = 1'b1;
								cnt_d  = '0;
								if (req.kind == bdrb_pkg::K_FIND_BACK) begin
									ram_raddr = bdrb_pkg::slot(head_q - bdrb_pkg::PTR_W'(1), mask);
								end
							end
						end
						bdrb_pkg::K_CLEAR: begin
							head_d = '0;
							tail_d = '0;
						end
						default: begin
							rsp_d.status = bdrb_pkg::STAT_OK;
						end
					endcase
					rsp_d.occupancy = bdrb_pkg::IDX_W'(head_d - tail_d);
				end
			end
			bdrb_pkg::ST_POP: begin
				if (out_free) begin
					ld              = 1'b1;
					rsp_d.data_out  = ram_rdata;
					rsp_d.occupancy = bdrb_pkg::IDX_W'(occ);
					rsp_d.last      = (left_q == bdrb_pkg::AMT_W'(1));
					left_d          = left_q - bdrb_pkg::AMT_W'(1);
					// fetch the next byte while this one goes out
					if (!rsp_d.last) begin
						ram_re = 1'b1;
						if (back_q) begin
							head_d    = head_q - bdrb_pkg::PTR_W'(1);
							ram_raddr = bdrb_pkg::slot(head_d, mask);
						end else begin
							tail_d = tail_q + bdrb_pkg::PTR_W'(1);
						end
					end
				end
			end
			bdrb_pkg::ST_FIND: begin
				rsp_d.occupancy = bdrb_pkg::IDX_W'(occ);
				if (hit) begin
					ld          = 1'b1;
					rsp_d.index = bdrb_pkg::IDX_W'(cnt_q);
				end else if (find_end) begin
					ld           = 1'b1;
					rsp_d.status = bdrb_pkg::STAT_NOT_FOUND;
					rsp_d.index  = bdrb_pkg::IDX_W'(occ);
				end else begin
					ram_re    = 1'b1;
					ram_raddr = bdrb_pkg::slot(walk_ptr, mask);
					cnt_d     = nxt_cnt;
				end
			end
			default: begin
				ld = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bdrb_pkg::ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			cap_log2_q  <= bdrb_pkg::CAP_LOG2_RST;
			rsp_valid_q <= 1'b0;
			left_q      <= '0;
			cnt_q       <= '0;
		end else begin
			state_q <= state_d;
			left_q  <= left_d;
			cnt_q   <= cnt_d;
			if (cfg_acc) begin
				cap_log2_q <= cfg_data;
				head_q     <= '0;
				tail_q     <= '0;
			end else begin
				head_q <= head_d;
				tail_q <= tail_d;
			end
			if (ld) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		key_q  <= key_d;
		back_q <= back_d;
		if (ld) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	bdrb_ram #(
		.WIDTH(8),
		.DEPTH(bdrb_pkg::DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(req.data_in),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

endmodule

// File: rtl/core/bdrb_ram.sv
// generic single-port-write, single-port-read ram with registered read
module bdrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/bdrb_chk.sv
// port-level checks for the byte deque ring buffer, bound to the top level
module bdrb_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_ready,
	input bdrb_pkg::req_t             req,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input bdrb_pkg::rsp_t             rsp,
	input logic                       cfg_valid,
	input logic                       cfg_ready,
	input logic [bdrb_pkg::CFG_W-1:0] cfg_data
);

	// a held result word keeps still
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result word changed while stalled");

	// a push always answers with a single final word on the next cycle
	a_push_answer: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req.kind == bdrb_pkg::K_PUSH_BACK ||
		req.kind == bdrb_pkg::K_PUSH_FRONT || req.kind == bdrb_pkg::K_OVERWRITE)
		|=> rsp_valid && rsp.last && rsp.data_out == 8'd0)
		else $error("push did not answer with one final word");

	// an absent byte reports the occupancy as its index
	a_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == bdrb_pkg::STAT_NOT_FOUND |-> rsp.index == rsp.occupancy)
		else $error("not-found index differs from occupancy");

	// empty status only with nothing held, on a final word
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == bdrb_pkg::STAT_EMPTY |-> rsp.occupancy == '0 && rsp.last)
		else $error("empty status with bytes held");

	// cfg_ready and cfg_data are watched through the port list only
	logic unused_cfg;
	assign unused_cfg = cfg_valid & cfg_ready & (^cfg_data);

endmodule

bind byte_deque_ring_buffer_unit bdrb_chk u_bdrb_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_ready(req_ready),
	.req      (req),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp),
	.cfg_valid(cfg_valid),
	.cfg_ready(cfg_ready),
	.cfg_data (cfg_data)
);
